FILE: hw/rtl/smx_pkg.sv
`timescale 1ns / 1ps
package smx_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_LEN_DEF         = 64;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // Width of a run length as it travels from front to back (covers the whole MAX_LEN range).
  localparam int LEN_W = 7;

  // log2(e) in Q.16 and ln(2) in Q.32.
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;

  // Reset value of the running maximum.
  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;

  // Saturation limits of a Q8.16 result.
  localparam logic signed [23:0] VALUE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VALUE_MIN = 24'sh800000;

  // Mode register codes.
  localparam logic MODE_FORWARD  = 1'b0;
  localparam logic MODE_BACKWARD = 1'b1;

  // One closed vector handed from the front to the back.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic signed [15:0] max_logit;
    logic              ovf;
    logic              mode;
    logic              bank;
  } run_desc_t;

  // Sequencer states of the back part.
  typedef enum logic [4:0] {
    B_IDLE,
    B_EXP_RD,
    B_EXP_MUL,
    B_EXP_IDX,
    B_EXP_LUT,
    B_EXP_WR,
    B_DIV_RD,
    B_DIV_START,
    B_DIV_WAIT,
    B_DOT_RD,
    B_DOT_MUL,
    B_DOT_ACC,
    B_DOT_FIN,
    B_OUT_RD,
    B_OUT_DIFF,
    B_OUT_MUL,
    B_OUT_EMIT
  } back_state_t;

  // round(65536 * e^-y) for y in Q.32, by a series up to the y^16 term; used at elaboration only.
  function automatic logic [16:0] exp_table_entry(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 17'((sum + 64'd32768) >> 16);
  endfunction

endpackage

FILE: hw/rtl/smx_ram.sv
`timescale 1ns / 1ps
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/smx_div.sv
`timescale 1ns / 1ps
module smx_div
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [22:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic        busy;
  logic [5:0]  step;
  logic [32:0] num_sh;
  logic [22:0] rem;
  logic [23:0] rem_sh;
  logic        fits;

  // Shift in the next numerator bit and try the subtraction.
  assign rem_sh = {rem, num_sh[32]};
  assign fits   = rem_sh >= {1'b0, den};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[31:0], 1'b0};
      rem    <= fits ? 23'(rem_sh - {1'b0, den}) : rem_sh[22:0];
      quot   <= {quot[15:0], fits};
    end
  end

endmodule

FILE: hw/rtl/smx_front.sv
`timescale 1ns / 1ps
module smx_front
  import smx_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [15:0]         logit,
  input  logic signed [15:0]         gradient,
  input  logic                       last,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  output logic                       wr_en,
  output logic [$clog2(MAX_LEN):0]   wr_addr,
  output logic signed [15:0]         wr_logit,
  output logic signed [15:0]         wr_grad,
  output logic                       desc_valid,
  output run_desc_t                  desc,
  input  logic                       desc_pop
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic                     mode;
  logic [CNT_W-1:0]         count;
  logic signed [15:0]       run_max;
  logic                     run_ovf;
  logic                     bank;
  run_desc_t                queue [2];
  logic                     q_wr;
  logic                     q_rd;
  logic [1:0]               q_cnt;

  logic                     accept;
  logic                     store;
  logic                     close;
  logic [CNT_W-1:0]         count_new;
  logic signed [15:0]       max_new;
  logic                     ovf_new;

  // Classify the transaction: stored, dropped for capacity, and whether it closes the vector.
  assign full      = q_cnt == 2'd2;
  assign accept    = push && !full;
  assign store     = accept && (count < CNT_W'(MAX_LEN));
  assign close     = accept && last;
  assign count_new = count + CNT_W'(store);
  assign max_new   = (store && (logit > run_max)) ? logit : run_max;
  assign ovf_new   = run_ovf | (accept & !store);

  // Element write into the bank being filled.
  assign wr_en    = store;
  assign wr_addr  = {bank, count[IDX_W-1:0]};
  assign wr_logit = logit;
  assign wr_grad  = gradient;

  // Head of the run queue.
  assign desc_valid = q_cnt != 2'd0;
  assign desc       = queue[q_rd];

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FORWARD;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // Running state of the vector being loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run_max <= LOGIT_MIN;
      run_ovf <= 1'b0;
      bank    <= 1'b0;
    end else if (close) begin
      count   <= '0;
      run_max <= LOGIT_MIN;
      run_ovf <= 1'b0;
      bank    <= !bank;
    end else if (accept) begin
      count   <= count_new;
      run_max <= max_new;
      run_ovf <= ovf_new;
    end
  end

  // Two-entry run queue; each entry owns one bank of the stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (close) begin
        q_wr <= !q_wr;
      end
      if (desc_pop) begin
        q_rd <= !q_rd;
      end
      q_cnt <= q_cnt + 2'(close) - 2'(desc_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      queue[q_wr] <= '{len: LEN_W'(count_new), max_logit: max_new, ovf: ovf_new,
                       mode: mode, bank: bank};
    end
  end

endmodule

FILE: hw/rtl/smx_back.sv
`timescale 1ns / 1ps
module smx_back
  import smx_pkg::*;
#(
  parameter int MAX_LEN         = MAX_LEN_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      desc_valid,
  input  run_desc_t                 desc,
  output logic                      desc_pop,
  output logic [$clog2(MAX_LEN):0]  mem_addr,
  input  logic signed [15:0]        logit_q,
  input  logic signed [15:0]        grad_q,
  input  logic [16:0]               exp_q,
  output logic                      exp_we,
  output logic [16:0]               exp_wdata,
  output logic                      div_start,
  output logic [32:0]               div_num,
  output logic [22:0]               div_den,
  input  logic                      div_done,
  input  logic [16:0]               div_quot,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [23:0]        value,
  output logic [5:0]                index,
  output logic                      end_of_vector,
  output logic                      overflow
);

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int TAB_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int ACC_W  = 34 + $clog2(MAX_LEN);
  localparam int DOT_W  = ACC_W - 8;
  localparam int DIFF_W = DOT_W + 1;
  localparam int PROD_W = DIFF_W + 18;

  // Table of 2^(-i/EXP_TABLE_DEPTH) in Q1.16, fixed at elaboration.
  logic [16:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar t = 0; t < EXP_TABLE_DEPTH; t++) begin : g_tab
    localparam logic [63:0] Y = (64'(t) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
    assign exp_tab[t] = exp_table_entry(Y);
  end

  back_state_t              state;
  back_state_t              state_next;
  logic [LEN_W-1:0]         i;
  logic [LEN_W-1:0]         i_next;
  logic [LEN_W-1:0]         i_inc;
  logic                     last_elem;

  logic [22:0]              exp_sum;
  logic [33:0]              u_reg;
  logic                     kbig;
  logic [4:0]               kshift;
  logic [TAB_W-1:0]         idx_reg;
  logic [16:0]              tab_reg;
  logic [16:0]              exp_val;
  logic [16:0]              quot_val;
  logic [16:0]              m;
  logic [36:0]              fmul;
  logic [16:0]              s_reg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [33:0]       pg_reg;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DIFF_W-1:0] diff_reg;
  logic signed [PROD_W-1:0] prod_reg;
  logic signed [PROD_W-1:0] v_full;
  logic signed [23:0]       v_sat;
  logic                     out_valid;
  logic                     slot_free;
  logic                     emit;

  assign i_inc     = i + LEN_W'(1);
  assign last_elem = i_inc == desc.len;
  assign mem_addr  = {desc.bank, i[IDX_W-1:0]};
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;

  // exp(-m/256): shift and fraction of m*log2(e), then table and right shift.
  assign m        = 17'({desc.max_logit[15], desc.max_logit} - {logit_q[15], logit_q});
  assign fmul     = 37'(u_reg[23:0]) * 37'(EXP_TABLE_DEPTH);
  assign exp_val  = kbig ? '0 : (tab_reg >> kshift);
  assign quot_val = (exp_sum == '0) ? '0 : div_quot;

  // Divider operands: exp * 2^16 + sum/2 over sum.
  assign div_num = {exp_q, 16'd0} + 33'(exp_sum[22:1]);
  assign div_den = exp_sum;

  // Dot product rounding and the saturated result.
  assign acc_rnd = acc + ACC_W'(128);
  assign v_full  = (prod_reg + PROD_W'(32768)) >>> 16;
  always_comb begin
    if (v_full > PROD_W'(VALUE_MAX)) begin
      v_sat = VALUE_MAX;
    end else if (v_full < PROD_W'(VALUE_MIN)) begin
      v_sat = VALUE_MIN;
    end else begin
      v_sat = 24'(v_full);
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      i     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
    end
  end

  // Next state and control: exp pass, divide pass, dot pass (backward only), output pass.
  always_comb begin
    state_next = state;
    i_next     = i;
    desc_pop   = 1'b0;
    exp_we     = 1'b0;
    exp_wdata  = exp_val;
    div_start  = 1'b0;
    emit       = 1'b0;
    case (state)
      B_IDLE: begin
        if (desc_valid) begin
          i_next     = '0;
          state_next = B_EXP_RD;
        end
      end
      B_EXP_RD:  state_next = B_EXP_MUL;
      B_EXP_MUL: state_next = B_EXP_IDX;
      B_EXP_IDX: state_next = B_EXP_LUT;
      B_EXP_LUT: state_next = B_EXP_WR;
      B_EXP_WR: begin
        exp_we = 1'b1;
        if (last_elem) begin
          i_next     = '0;
          state_next = B_DIV_RD;
        end else begin
          i_next     = i_inc;
          state_next = B_EXP_RD;
        end
      end
      B_DIV_RD: state_next = B_DIV_START;
      B_DIV_START: begin
        div_start  = 1'b1;
        state_next = B_DIV_WAIT;
      end
      B_DIV_WAIT: begin
        if (div_done) begin
          exp_we    = 1'b1;
          exp_wdata = quot_val;
          if (last_elem) begin
            i_next     = '0;
            state_next = (desc.mode == MODE_BACKWARD) ? B_DOT_RD : B_OUT_RD;
          end else begin
            i_next     = i_inc;
            state_next = B_DIV_RD;
          end
        end
      end
      B_DOT_RD:  state_next = B_DOT_MUL;
      B_DOT_MUL: state_next = B_DOT_ACC;
      B_DOT_ACC: begin
        if (last_elem) begin
          i_next     = '0;
          state_next = B_DOT_FIN;
        end else begin
          i_next     = i_inc;
          state_next = B_DOT_RD;
        end
      end
      B_DOT_FIN:  state_next = B_OUT_RD;
      B_OUT_RD:   state_next = B_OUT_DIFF;
      B_OUT_DIFF: state_next = B_OUT_MUL;
      B_OUT_MUL:  state_next = B_OUT_EMIT;
      B_OUT_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (last_elem) begin
            desc_pop   = 1'b1;
            i_next     = '0;
            state_next = B_IDLE;
          end else begin
            i_next     = i_inc;
            state_next = B_OUT_RD;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Datapath registers, each loaded in the step that produces it.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        exp_sum <= '0;
        acc     <= '0;
        dot     <= '0;
      end
      B_EXP_MUL: u_reg <= 34'(m) * 34'(LOG2E_Q16);
      B_EXP_IDX: begin
        kbig    <= u_reg[33:24] >= 10'd17;
        kshift  <= u_reg[28:24];
        idx_reg <= fmul[24 +: TAB_W];
      end
      B_EXP_LUT: tab_reg <= exp_tab[idx_reg];
      B_EXP_WR:  exp_sum <= exp_sum + 23'(exp_val);
      B_DOT_MUL: pg_reg <= $signed({1'b0, exp_q}) * grad_q;
      B_DOT_ACC: acc <= acc + ACC_W'(pg_reg);
      B_DOT_FIN: dot <= DOT_W'(acc_rnd >>> 8);
      B_OUT_DIFF: begin
        s_reg    <= exp_q;
        diff_reg <= (DIFF_W'(grad_q) <<< 8) - DIFF_W'(dot);
      end
      B_OUT_MUL: prod_reg <= $signed({1'b0, s_reg}) * diff_reg;
      default: begin
      end
    endcase
  end

  // Result register between the sequencer and the output queue side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value         <= (desc.mode == MODE_BACKWARD) ? v_sat : 24'(s_reg);
      index         <= 6'(i);
      end_of_vector <= last_elem;
      overflow      <= desc.ovf;
    end
  end

endmodule

FILE: hw/rtl/softmax_forward_backward.sv
`timescale 1ns / 1ps
// Channel   Ports                                              Transaction
// input     push, full, logit, gradient, last                  push && !full
// result    empty, pop, value, index, end_of_vector, overflow  pop && !empty
// config    cfg_write, cfg_data                                cfg_write
//
// Loading takes one element per cycle while full is low. A closed vector is then worked
// off in an exponential pass, a divide pass with one divider run per probability, a dot
// product pass (backward only) and a result pass; the shared divider pass is the longest.
// Two store banks let the next vector load while one is worked off; full rises once
// both banks hold closed vectors. A stalled result holds the back part. rst is synchronous.
module softmax_forward_backward
  import smx_pkg::*;
#(
  parameter int MAX_LEN         = MAX_LEN_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] logit,
  input  logic signed [15:0] gradient,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] value,
  output logic [5:0]         index,
  output logic               end_of_vector,
  output logic               overflow,
  input  logic               cfg_write,
  input  logic               cfg_data
);

  localparam int ADDR_W = $clog2(MAX_LEN) + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [15:0]       wr_logit;
  logic signed [15:0]       wr_grad;
  logic                     desc_valid;
  run_desc_t                desc;
  logic                     desc_pop;
  logic [ADDR_W-1:0]        mem_addr;
  logic [15:0]              logit_q;
  logic [15:0]              grad_q;
  logic [16:0]              exp_q;
  logic                     exp_we;
  logic [16:0]              exp_wdata;
  logic                     div_start;
  logic [32:0]              div_num;
  logic [22:0]              div_den;
  logic                     div_done;
  logic [16:0]              div_quot;

  // Front: accepts elements, fills the stores, closes runs into the queue.
  smx_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst, .push, .full, .logit, .gradient, .last, .cfg_write, .cfg_data,
    .wr_en, .wr_addr, .wr_logit, .wr_grad, .desc_valid, .desc, .desc_pop
  );

  // Element stores, two banks each.
  smx_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_logit_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_logit), .raddr(mem_addr), .rdata(logit_q)
  );

  smx_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_grad_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_grad), .raddr(mem_addr), .rdata(grad_q)
  );

  smx_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_exp_ram (
    .clk, .we(exp_we), .waddr(mem_addr), .wdata(exp_wdata), .raddr(mem_addr), .rdata(exp_q)
  );

  // Shared divider for the normalisation.
  smx_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den), .done(div_done),
    .quot(div_quot)
  );

  // Back: works off one closed run at a time and delivers the results.
  smx_back #(.MAX_LEN(MAX_LEN), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
    .clk, .rst, .desc_valid, .desc, .desc_pop, .mem_addr,
    .logit_q(signed'(logit_q)), .grad_q(signed'(grad_q)), .exp_q,
    .exp_we, .exp_wdata, .div_start, .div_num, .div_den, .div_done, .div_quot,
    .empty, .pop, .value, .index, .end_of_vector, .overflow
  );

endmodule
